// ===== design/rnx_pkg.sv =====
// ----------------------------------------------------------------------------
// rnx_pkg
// Shared types and constants for the ring neighbour exclusion arbiter.
// ----------------------------------------------------------------------------
package rnx_pkg;

  localparam int unsigned MAX_DINERS_DEF = 10;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned MIN_W          = 4;
  localparam int unsigned GRANT_W        = 10;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned SNAP_POS       = 10;
  localparam int unsigned SNAP_W         = 2 * SNAP_POS;
  localparam int unsigned SIZE_W         = 4;

  localparam logic [MIN_W-1:0] MIN_DINERS_RST = 4'd2;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_THINKING = 2'd1,
    ST_WAITING  = 2'd2,
    ST_EATING   = 2'd3
  } diner_state_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_REQUEST = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_JOIN    = 2'd2,
    MODE_LEAVE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_MIN       = 3'd2,
    STATUS_BUSY      = 3'd3,
    STATUS_BAD_INDEX = 3'd4
  } status_e;

  typedef struct packed {
    logic capture;
    logic nbr;
    logic update;
    logic cfg_write;
  } cmd_t;

endpackage

// ===== design/rnx_ctrl.sv =====
// ----------------------------------------------------------------------------
// rnx_ctrl
// Sequencer for the arbiter: takes one beat, steps the datapath through
// neighbour lookup and update, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module rnx_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  output rnx_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NBR,
    S_UPD
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic        in_stall_q;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        cfg_ready_q;
  logic        out_free;
  logic        upd_go;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign upd_go      = (state_q == S_UPD) && out_free;
  assign out_valid_d = upd_go ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_ready_q <= 1'b1;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_q) begin
            state_q     <= S_NBR;
            in_stall_q  <= 1'b1;
            cfg_ready_q <= 1'b0;
          end
        end
        S_NBR: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            in_stall_q  <= 1'b0;
            cfg_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i && !in_stall_q;
    cmd_o.nbr       = (state_q == S_NBR);
    cmd_o.update    = upd_go;
    cmd_o.cfg_write = cfg_valid_i && cfg_ready_q;
  end

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = cfg_ready_q;

endmodule

// ===== design/rnx_datapath.sv =====
// ----------------------------------------------------------------------------
// rnx_datapath
// Client state ring, live count, minimum register, neighbour lookup and the
// result register of the arbiter.
// ----------------------------------------------------------------------------
module rnx_datapath #(
  parameter int unsigned MaxDiners = rnx_pkg::MAX_DINERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rnx_pkg::cmd_t                 cmd_i,
  input  logic [rnx_pkg::MODE_W-1:0]    mode_i,
  input  logic [rnx_pkg::IDX_W-1:0]     diner_index_i,
  input  logic [rnx_pkg::MIN_W-1:0]     cfg_data_i,
  output logic [rnx_pkg::GRANT_W-1:0]   grant_mask_o,
  output logic [rnx_pkg::STATUS_W-1:0]  status_o,
  output logic [rnx_pkg::SNAP_W-1:0]    state_snapshot_o,
  output logic [rnx_pkg::SIZE_W-1:0]    ring_size_o
);

  localparam int unsigned PosW  = $clog2(MaxDiners);
  localparam int unsigned CntW  = $clog2(MaxDiners + 1);
  localparam int unsigned CmpW  = (CntW > rnx_pkg::MIN_W) ? CntW : rnx_pkg::MIN_W;
  localparam int unsigned SizeW = rnx_pkg::SIZE_W;

  rnx_pkg::mode_e               mode_q;
  logic [rnx_pkg::IDX_W-1:0]    idx_q;
  logic [PosW-1:0]              p_q, l_q, r_q, ll_q, rr_q;
  logic [PosW-1:0]              p_d, l_d, r_d, ll_d, rr_d;
  rnx_pkg::diner_state_e        state_q [MaxDiners];
  rnx_pkg::diner_state_e        st_n [MaxDiners];
  logic [CntW-1:0]              cnt_q, cnt_n;
  logic [rnx_pkg::MIN_W-1:0]    min_q;
  logic [MaxDiners-1:0]         grant_n;
  rnx_pkg::status_e             status_n;
  logic                         bad_idx;
  logic                         at_min;
  logic [rnx_pkg::GRANT_W-1:0]  grant_w;
  logic [rnx_pkg::SNAP_W-1:0]   snap_w;
  logic [rnx_pkg::GRANT_W-1:0]  grant_q;
  rnx_pkg::status_e             status_q;
  logic [rnx_pkg::SNAP_W-1:0]   snap_q;
  logic [rnx_pkg::SIZE_W-1:0]   size_q;

  function automatic logic [PosW-1:0] left_of(input logic [PosW-1:0] p,
                                              input logic [CntW-1:0] cnt);
    logic [CntW-1:0] last;
    last = cnt - CntW'(1);
    if (p == '0) begin
      return last[PosW-1:0];
    end
    return p - PosW'(1);
  endfunction

  function automatic logic [PosW-1:0] right_of(input logic [PosW-1:0] p,
                                               input logic [CntW-1:0] cnt);
    logic [CntW-1:0] nxt;
    nxt = CntW'(p) + CntW'(1);
    if (nxt >= cnt) begin
      return '0;
    end
    return nxt[PosW-1:0];
  endfunction

  always_comb begin
    logic [CntW-1:0] last;
    last = cnt_q - CntW'(1);
    if (mode_q == rnx_pkg::MODE_LEAVE) begin
      p_d = last[PosW-1:0];
    end else begin
      p_d = PosW'(idx_q);
    end
    l_d  = left_of(p_d, cnt_q);
    r_d  = right_of(p_d, cnt_q);
    ll_d = left_of(l_d, cnt_q);
    rr_d = right_of(r_d, cnt_q);
  end

  assign bad_idx = CmpW'(idx_q) >= CmpW'(cnt_q);
  assign at_min  = (CmpW'(cnt_q) <= CmpW'(min_q)) || (cnt_q == '0);

  always_comb begin
    st_n     = state_q;
    cnt_n    = cnt_q;
    grant_n  = '0;
    status_n = rnx_pkg::STATUS_OK;
    case (mode_q)
      rnx_pkg::MODE_REQUEST: begin
        if (bad_idx) begin
          status_n = rnx_pkg::STATUS_BAD_INDEX;
        end else begin
          st_n[p_q] = rnx_pkg::ST_WAITING;
          if (st_n[l_q] != rnx_pkg::ST_EATING && st_n[r_q] != rnx_pkg::ST_EATING) begin
            st_n[p_q]    = rnx_pkg::ST_EATING;
            grant_n[p_q] = 1'b1;
          end
        end
      end
      rnx_pkg::MODE_RELEASE: begin
        if (bad_idx) begin
          status_n = rnx_pkg::STATUS_BAD_INDEX;
        end else begin
          st_n[p_q] = rnx_pkg::ST_THINKING;
          if (st_n[l_q] == rnx_pkg::ST_WAITING && st_n[ll_q] != rnx_pkg::ST_EATING) begin
            st_n[l_q]    = rnx_pkg::ST_EATING;
            grant_n[l_q] = 1'b1;
          end
          if (st_n[r_q] == rnx_pkg::ST_WAITING && st_n[rr_q] != rnx_pkg::ST_EATING) begin
            st_n[r_q]    = rnx_pkg::ST_EATING;
            grant_n[r_q] = 1'b1;
          end
        end
      end
      rnx_pkg::MODE_JOIN: begin
        if (cnt_q >= CntW'(MaxDiners)) begin
          status_n = rnx_pkg::STATUS_FULL;
        end else begin
          st_n[cnt_q[PosW-1:0]] = rnx_pkg::ST_THINKING;
          cnt_n                 = cnt_q + CntW'(1);
        end
      end
      rnx_pkg::MODE_LEAVE: begin
        if (at_min) begin
          status_n = rnx_pkg::STATUS_MIN;
        end else if (state_q[l_q] == rnx_pkg::ST_EATING &&
                     state_q[r_q] == rnx_pkg::ST_EATING) begin
          status_n = rnx_pkg::STATUS_BUSY;
        end else begin
          st_n[p_q] = rnx_pkg::ST_NONE;
          cnt_n     = cnt_q - CntW'(1);
        end
      end
      default: begin
        status_n = rnx_pkg::STATUS_OK;
      end
    endcase
  end

  for (genvar i = 0; i < rnx_pkg::SNAP_POS; i++) begin : g_out
    if (i < MaxDiners) begin : g_live
      assign grant_w[i]       = grant_n[i];
      assign snap_w[2*i +: 2] = st_n[i];
    end else begin : g_pad
      assign grant_w[i]       = 1'b0;
      assign snap_w[2*i +: 2] = 2'b00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxDiners; i++) begin
        state_q[i] <= rnx_pkg::ST_NONE;
      end
      cnt_q <= '0;
      min_q <= rnx_pkg::MIN_DINERS_RST;
    end else begin
      if (cmd_i.cfg_write) begin
        min_q <= cfg_data_i;
      end
      if (cmd_i.update) begin
        state_q <= st_n;
        cnt_q   <= cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= rnx_pkg::mode_e'(mode_i);
      idx_q  <= diner_index_i;
    end
    if (cmd_i.nbr) begin
      p_q  <= p_d;
      l_q  <= l_d;
      r_q  <= r_d;
      ll_q <= ll_d;
      rr_q <= rr_d;
    end
    if (cmd_i.update) begin
      grant_q  <= grant_w;
      status_q <= status_n;
      snap_q   <= snap_w;
      size_q   <= SizeW'(cnt_n);
    end
  end

  assign grant_mask_o     = grant_q;
  assign status_o         = status_q;
  assign state_snapshot_o = snap_q;
  assign ring_size_o      = size_q;

endmodule

// ===== design/ring_neighbour_exclusion_arbiter.sv =====
// A beat is captured into the mode and index registers, then the neighbour positions are
// registered, then the update step registers the result beat, which is held until it is taken.
// A new item is not accepted until the update step of the last one is done (in_stall_o stays
// high); a held result stalls the update step of the next item until it is taken.
// Reset: all ring positions empty, client count zero, minimum ring size two.
// ----------------------------------------------------------------------------
// ring_neighbour_exclusion_arbiter
// Keeps a ring of clients and grants each one only while no ring neighbour
// holds a grant; clients may join at or leave from the end of the ring.
// ----------------------------------------------------------------------------
module ring_neighbour_exclusion_arbiter #(
  parameter int unsigned MaxDiners = rnx_pkg::MAX_DINERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rnx_pkg::MODE_W-1:0]    mode_i,
  input  logic [rnx_pkg::IDX_W-1:0]     diner_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rnx_pkg::GRANT_W-1:0]   grant_mask_o,
  output logic [rnx_pkg::STATUS_W-1:0]  status_o,
  output logic [rnx_pkg::SNAP_W-1:0]    state_snapshot_o,
  output logic [rnx_pkg::SIZE_W-1:0]    ring_size_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rnx_pkg::MIN_W-1:0]     cfg_data_i
);

  rnx_pkg::cmd_t cmd;

  rnx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  rnx_datapath #(
    .MaxDiners (MaxDiners)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .mode_i           (mode_i),
    .diner_index_i    (diner_index_i),
    .cfg_data_i       (cfg_data_i),
    .grant_mask_o     (grant_mask_o),
    .status_o         (status_o),
    .state_snapshot_o (state_snapshot_o),
    .ring_size_o      (ring_size_o)
  );

endmodule
